// ===== rtl/shtag_pkg.sv =====
// ----------------------------------------------------------------------------
// shtag_pkg
// Shared types, constants and SHA-256 helper functions for the share tagger.
// ----------------------------------------------------------------------------
package shtag_pkg;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_SECRET = 2'd1,
    OP_EXPECT = 2'd2,
    OP_BEGIN  = 2'd3
  } op_e;

  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;
  localparam logic [7:0] PAD_MARK  = 8'h80;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // domain separation string "VCSMshare1"
  function automatic logic [7:0] domain_byte(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'h56;
      4'd1:    r = 8'h43;
      4'd2:    r = 8'h53;
      4'd3:    r = 8'h4d;
      4'd4:    r = 8'h73;
      4'd5:    r = 8'h68;
      4'd6:    r = 8'h61;
      4'd7:    r = 8'h72;
      4'd8:    r = 8'h65;
      4'd9:    r = 8'h31;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// ===== rtl/share_hmac_sha256_tagger.sv =====
// A start beat feeds 64 key bytes and 12 header bytes through the byte
// sequencer, plus one compression; a secret beat feeds one byte, plus a
// compression when it fills a block. The final beat adds padding, the outer key
// block and the digest, with three to four compressions.
// Throughput is set by the single shared round unit: one SHA-256 round a cycle.
// Reset: key clears to zero, hash state to the IV, batch flag to one.
// ----------------------------------------------------------------------------
// share_hmac_sha256_tagger
// HMAC-SHA256 tag generation and constant-time verification per secret share,
// built around one iterative SHA-256 round unit and a byte sequencer.
// ----------------------------------------------------------------------------
module share_hmac_sha256_tagger #(
  parameter int MAX_SECRET = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  share_x_i,
  input  logic [7:0]  share_len_i,
  input  logic        verify_mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] tag_word_o,
  output logic        word_last_o,
  output logic        is_verdict_o,
  output logic        share_ok_o,
  output logic        batch_ok_o
);
  import shtag_pkg::*;

  localparam logic [7:0] MAX_LEN = 8'(MAX_SECRET);

  typedef enum logic [2:0] {
    S_IDLE, S_FEED, S_ROUND, S_ADD, S_NEXT, S_OUT, S_VERD
  } state_e;

  typedef enum logic [3:0] {
    SRC_IKEY, SRC_DOM, SRC_SEC, SRC_IPAD, SRC_SWAP,
    SRC_OKEY, SRC_DIG, SRC_OPAD, SRC_FIN
  } src_e;

  typedef enum logic [1:0] {
    PH_IDLE, PH_SECRET, PH_EXPECT
  } phase_e;

  state_e      state_q, state_d;
  src_e        src_q, src_d;
  phase_e      phase_q, phase_d;
  logic [63:0] key_q [4];
  logic [63:0] key_d [4];
  logic [31:0] hash_q [8];
  logic [31:0] hash_d [8];
  logic [5:0]  cnt_q, cnt_d;
  logic [5:0]  fill_q, fill_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [15:0] mlen_q, mlen_d;
  logic [7:0]  left_q, left_d;
  logic        mode_q, mode_d;
  logic        pfirst_q, pfirst_d;
  logic        plen_q, plen_d;
  logic [4:0]  tidx_q, tidx_d;
  logic [7:0]  diff_q, diff_d;
  logic        batch_q, batch_d;
  logic        ok_q, ok_d;
  logic [1:0]  oidx_q, oidx_d;

  // datapath, no reset
  logic [31:0] w_q [16];
  logic [31:0] wk_q [8];
  logic [31:0] inner_q [8];
  logic [23:0] acc_q;
  logic [7:0]  x_q, sec_q;

  logic        in_acc, feed_en, round_en, load_wk, swap_en;
  logic [7:0]  feed_byte, kbyte, ibyte, lbyte, hbyte, new_diff;
  logic [63:0] kword, lword;
  logic [31:0] iword, hword, t1, t2, w_new;
  logic        src_done;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // byte source mux
  always_comb begin
    kword = key_q[cnt_q[4:3]];
    kbyte = cnt_q[5] ? 8'h00 : kword[{~cnt_q[2:0], 3'b000} +: 8];
    iword = inner_q[cnt_q[4:2]];
    ibyte = iword[{~cnt_q[1:0], 3'b000} +: 8];
    lword = {45'd0, mlen_q, 3'd0};
    lbyte = lword[{~cnt_q[2:0], 3'b000} +: 8];
    case (src_q)
      SRC_IKEY: feed_byte = kbyte ^ IPAD_BYTE;
      SRC_OKEY: feed_byte = kbyte ^ OPAD_BYTE;
      SRC_DOM: begin
        if (cnt_q < 6'd10)       feed_byte = domain_byte(cnt_q[3:0]);
        else if (cnt_q == 6'd10) feed_byte = x_q;
        else                     feed_byte = left_q;
      end
      SRC_SEC: feed_byte = sec_q;
      SRC_IPAD, SRC_OPAD: feed_byte = plen_q ? lbyte : (pfirst_q ? PAD_MARK : 8'h00);
      SRC_DIG: feed_byte = ibyte;
      default: feed_byte = 8'h00;
    endcase
    case (src_q)
      SRC_IKEY, SRC_OKEY: src_done = (cnt_q == 6'd63);
      SRC_DOM:            src_done = (cnt_q == 6'd11);
      SRC_SEC:            src_done = 1'b1;
      SRC_IPAD, SRC_OPAD: src_done = plen_q && (cnt_q == 6'd7);
      SRC_DIG:            src_done = (cnt_q == 6'd31);
      default:            src_done = 1'b0;
    endcase
  end

  // round unit and expected-byte comparison
  always_comb begin
    t1 = wk_q[7] + bsig1(wk_q[4]) + ((wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]))
       + SHA_K[rnd_q] + w_q[0];
    t2 = bsig0(wk_q[0]) + ((wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]));
    w_new = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
    hword = hash_q[tidx_q[4:2]];
    hbyte = hword[{~tidx_q[1:0], 3'b000} +: 8];
    new_diff = diff_q | (hbyte ^ data_byte_i);
  end

  always_comb begin
    state_d  = state_q;
    src_d    = src_q;
    phase_d  = phase_q;
    key_d    = key_q;
    hash_d   = hash_q;
    cnt_d    = cnt_q;
    fill_d   = fill_q;
    rnd_d    = rnd_q;
    mlen_d   = mlen_q;
    left_d   = left_q;
    mode_d   = mode_q;
    pfirst_d = pfirst_q;
    plen_d   = plen_q;
    tidx_d   = tidx_q;
    diff_d   = diff_q;
    batch_d  = batch_q;
    ok_d     = ok_q;
    oidx_d   = oidx_q;
    feed_en  = 1'b0;
    round_en = 1'b0;
    load_wk  = 1'b0;
    swap_en  = 1'b0;

    if (cfg_we_i) key_d[cfg_idx_i] = cfg_data_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (operation_i)
            OP_BEGIN: begin
              batch_d = 1'b1;
              phase_d = PH_IDLE;
            end
            OP_START: begin
              left_d   = (share_len_i > MAX_LEN) ? MAX_LEN : share_len_i;
              mode_d   = verify_mode_i;
              hash_d   = SHA_IV;
              fill_d   = '0;
              mlen_d   = '0;
              src_d    = SRC_IKEY;
              cnt_d    = '0;
              pfirst_d = 1'b1;
              plen_d   = 1'b0;
              phase_d  = PH_SECRET;
              state_d  = S_FEED;
            end
            OP_SECRET: begin
              if (phase_q == PH_SECRET && left_q != 8'd0) begin
                src_d   = SRC_SEC;
                state_d = S_FEED;
              end
            end
            default: begin
              if (phase_q == PH_EXPECT) begin
                if (tidx_q != 5'd31) begin
                  diff_d = new_diff;
                  tidx_d = tidx_q + 5'd1;
                end else begin
                  ok_d    = (new_diff == 8'd0);
                  batch_d = batch_q & (new_diff == 8'd0);
                  diff_d  = '0;
                  tidx_d  = '0;
                  phase_d = PH_IDLE;
                  state_d = S_VERD;
                end
              end
            end
          endcase
        end
      end
      S_FEED: begin
        feed_en = 1'b1;
        fill_d  = fill_q + 6'd1;
        if (src_q != SRC_IPAD && src_q != SRC_OPAD) mlen_d = mlen_q + 16'd1;
        if (src_q == SRC_SEC) left_d = left_q - 8'd1;
        if (src_done) begin
          cnt_d    = '0;
          pfirst_d = 1'b1;
          plen_d   = 1'b0;
          case (src_q)
            SRC_IKEY: src_d = SRC_DOM;
            SRC_DOM:  src_d = SRC_SEC;
            SRC_IPAD: src_d = SRC_SWAP;
            SRC_OKEY: src_d = SRC_DIG;
            SRC_DIG:  src_d = SRC_OPAD;
            SRC_OPAD: src_d = SRC_FIN;
            default:  src_d = src_q;
          endcase
        end else if ((src_q == SRC_IPAD || src_q == SRC_OPAD) && !plen_q) begin
          pfirst_d = 1'b0;
          // length field starts once the block reaches 56 bytes
          if (fill_q == 6'd55) plen_d = 1'b1;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
        if (fill_q == 6'd63) begin
          load_wk = 1'b1;
          rnd_d   = '0;
          state_d = S_ROUND;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_ROUND: begin
        round_en = 1'b1;
        rnd_d    = rnd_q + 6'd1;
        if (rnd_q == 6'd63) state_d = S_ADD;
      end
      S_ADD: begin
        for (int i = 0; i < 8; i++) hash_d[i] = hash_q[i] + wk_q[i];
        state_d = S_NEXT;
      end
      S_NEXT: begin
        case (src_q)
          SRC_SEC: begin
            if (left_q == 8'd0) begin
              src_d    = SRC_IPAD;
              cnt_d    = '0;
              pfirst_d = 1'b1;
              plen_d   = 1'b0;
              state_d  = S_FEED;
            end else begin
              state_d = S_IDLE;
            end
          end
          SRC_SWAP: begin
            swap_en = 1'b1;
            hash_d  = SHA_IV;
            fill_d  = '0;
            mlen_d  = '0;
            src_d   = SRC_OKEY;
            state_d = S_FEED;
          end
          SRC_FIN: begin
            if (mode_q) begin
              phase_d = PH_EXPECT;
              tidx_d  = '0;
              diff_d  = '0;
              state_d = S_IDLE;
            end else begin
              phase_d = PH_IDLE;
              oidx_d  = '0;
              state_d = S_OUT;
            end
          end
          default: state_d = S_FEED;
        endcase
      end
      S_OUT: begin
        if (!out_stall_i) begin
          oidx_d = oidx_q + 2'd1;
          if (oidx_q == 2'd3) state_d = S_IDLE;
        end
      end
      S_VERD: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      src_q    <= SRC_IKEY;
      phase_q  <= PH_IDLE;
      key_q    <= '{default: '0};
      hash_q   <= SHA_IV;
      cnt_q    <= '0;
      fill_q   <= '0;
      rnd_q    <= '0;
      mlen_q   <= '0;
      left_q   <= '0;
      mode_q   <= 1'b0;
      pfirst_q <= 1'b1;
      plen_q   <= 1'b0;
      tidx_q   <= '0;
      diff_q   <= '0;
      batch_q  <= 1'b1;
      ok_q     <= 1'b0;
      oidx_q   <= '0;
    end else begin
      state_q  <= state_d;
      src_q    <= src_d;
      phase_q  <= phase_d;
      key_q    <= key_d;
      hash_q   <= hash_d;
      cnt_q    <= cnt_d;
      fill_q   <= fill_d;
      rnd_q    <= rnd_d;
      mlen_q   <= mlen_d;
      left_q   <= left_d;
      mode_q   <= mode_d;
      pfirst_q <= pfirst_d;
      plen_q   <= plen_d;
      tidx_q   <= tidx_d;
      diff_q   <= diff_d;
      batch_q  <= batch_d;
      ok_q     <= ok_d;
      oidx_q   <= oidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && operation_i == OP_START)  x_q   <= share_x_i;
    if (in_acc && operation_i == OP_SECRET) sec_q <= data_byte_i;
    if (feed_en) begin
      acc_q <= {acc_q[15:0], feed_byte};
      if (fill_q[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= {acc_q, feed_byte};
      end
    end
    if (round_en) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      wk_q[0] <= t1 + t2;
      wk_q[1] <= wk_q[0];
      wk_q[2] <= wk_q[1];
      wk_q[3] <= wk_q[2];
      wk_q[4] <= wk_q[3] + t1;
      wk_q[5] <= wk_q[4];
      wk_q[6] <= wk_q[5];
      wk_q[7] <= wk_q[6];
    end
    if (load_wk) wk_q <= hash_q;
    if (swap_en) inner_q <= hash_q;
  end

  assign out_valid_o  = (state_q == S_OUT) || (state_q == S_VERD);
  assign tag_word_o   = (state_q == S_OUT) ? {hash_q[{oidx_q, 1'b0}], hash_q[{oidx_q, 1'b1}]}
                                           : 64'd0;
  assign word_last_o  = (state_q == S_OUT) && (oidx_q == 2'd3);
  assign is_verdict_o = (state_q == S_VERD);
  assign share_ok_o   = (state_q == S_VERD) && ok_q;
  assign batch_ok_o   = (state_q == S_VERD) && batch_q;

`ifndef SYNTHESIS
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result pending while input open");
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && rnd_q == 6'd63) |=> state_q == S_ADD)
    else $error("compression did not end after 64 rounds");
  a_verd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VERD) |-> (phase_q == PH_IDLE && tidx_q == 5'd0))
    else $error("verdict with verify still open");
  a_left_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= MAX_LEN)
    else $error("secret count above maximum");
  a_verd_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VERD && batch_q) |-> ok_q)
    else $error("batch ok without share ok");
`endif

endmodule

// ===== tb/shtag_checker.sv =====
// ----------------------------------------------------------------------------
// shtag_checker
// Watches the config port and both handshake channels of the share tagger,
// predicts the HMAC-SHA256 tag words and verify verdicts of every accepted
// beat, and compares each accepted result beat field by field.
// ----------------------------------------------------------------------------
module shtag_checker
  import shtag_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         in_valid_i,
  input  logic         in_stall_i,
  input  logic [1:0]   operation_i,
  input  logic [7:0]   share_x_i,
  input  logic [7:0]   share_len_i,
  input  logic         verify_mode_i,
  input  logic [7:0]   data_byte_i,
  input  logic         out_valid_i,
  input  logic         out_stall_i,
  input  logic [63:0]  tag_word_i,
  input  logic         word_last_i,
  input  logic         is_verdict_i,
  input  logic         share_ok_i,
  input  logic         batch_ok_i,
  output int           pending_o,
  output int           fail_o,
  output logic [255:0] digest_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {ST_IDLE, ST_SECRET, ST_EXPECT} share_state_e;

  typedef struct packed {
    logic [63:0] tag_word;
    logic        word_last;
    logic        is_verdict;
    logic        share_ok;
    logic        batch_ok;
  } result_t;

  localparam int SECRET_MAX = 64;
  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [7:0] DOMAIN [10] = '{
    8'h56, 8'h43, 8'h53, 8'h4d, 8'h73, 8'h68, 8'h61, 8'h72, 8'h65, 8'h31
  };

  logic [63:0]  key_q [4];
  logic [31:0]  hv [8];
  logic [31:0]  inner_hv [8];
  logic [7:0]   blk [64];
  int           fill;
  logic [15:0]  msg_len;
  int           secret_left;
  share_state_e state;
  logic         verify_q;
  int           tag_pos;
  logic [7:0]   diff;
  logic         batch_q;
  result_t      tag_results [$];
  int           fails;

  assign pending_o = tag_results.size();
  assign fail_o    = fails;
  assign digest_o  = {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
    e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + RK[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
    hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
  endtask

  task automatic hash_open();
    for (int i = 0; i < 8; i++) hv[i] = IV[i];
    fill = 0;
    msg_len = '0;
  endtask

  task automatic take_byte(input logic [7:0] v);
    blk[fill] = v;
    fill++;
    msg_len++;
    if (fill >= 64) begin
      compress_block();
      fill = 0;
    end
  endtask

  task automatic hash_close();
    logic [31:0] bits;
    bits = {16'd0, msg_len} * 8;
    blk[fill] = 8'h80;
    fill++;
    if (fill > 56) begin
      while (fill < 64) begin blk[fill] = 8'h00; fill++; end
      compress_block();
      fill = 0;
    end
    while (fill < 56) begin blk[fill] = 8'h00; fill++; end
    for (int i = 56; i < 60; i++) blk[i] = 8'h00;
    {blk[60], blk[61], blk[62], blk[63]} = bits;
    compress_block();
    fill = 0;
  endtask

  function automatic logic [7:0] key_at(input int i);
    if (i >= 32) return 8'h00;
    return key_q[i/8][63 - 8*(i%8) -: 8];
  endfunction

  task automatic close_share();
    result_t r;
    hash_close();
    for (int i = 0; i < 8; i++) inner_hv[i] = hv[i];
    hash_open();
    for (int i = 0; i < 64; i++) take_byte(key_at(i) ^ 8'h5c);
    for (int i = 0; i < 32; i++) take_byte(inner_hv[i/4][31 - 8*(i%4) -: 8]);
    hash_close();
    if (verify_q) begin
      state = ST_EXPECT;
      tag_pos = 0;
      diff = '0;
    end else begin
      state = ST_IDLE;
      for (int i = 0; i < 4; i++) begin
        r = '0;
        r.tag_word = {hv[2*i], hv[2*i+1]};
        r.word_last = (i == 3);
        tag_results.push_back(r);
      end
    end
  endtask

  task automatic predict_beat(input logic [1:0] op, input logic [7:0] x,
                              input logic [7:0] len, input logic vm, input logic [7:0] b);
    result_t r;
    int n;
    case (op)
      OP_BEGIN: begin
        batch_q = 1'b1;
        state = ST_IDLE;
      end
      OP_START: begin
        n = (len > SECRET_MAX) ? SECRET_MAX : len;
        secret_left = n;
        verify_q = vm;
        hash_open();
        for (int i = 0; i < 64; i++) take_byte(key_at(i) ^ 8'h36);
        for (int i = 0; i < 10; i++) take_byte(DOMAIN[i]);
        take_byte(x);
        take_byte(n[7:0]);
        state = ST_SECRET;
        if (n == 0) close_share();
      end
      OP_SECRET: begin
        if (state == ST_SECRET && secret_left != 0) begin
          take_byte(b);
          secret_left--;
          if (secret_left == 0) close_share();
        end
      end
      default: begin
        if (state == ST_EXPECT) begin
          diff |= digest_o[255 - 8*tag_pos -: 8] ^ b;
          if (tag_pos < 31) begin
            tag_pos++;
          end else begin
            batch_q &= (diff == 0);
            state = ST_IDLE;
            tag_pos = 0;
            r = '0;
            r.is_verdict = 1'b1;
            r.share_ok = (diff == 0);
            r.batch_ok = batch_q;
            tag_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] = '0;
      hash_open();
      secret_left = 0;
      state = ST_IDLE;
      verify_q = 1'b0;
      tag_pos = 0;
      diff = '0;
      batch_q = 1'b1;
      tag_results.delete();
      fails = 0;
    end else begin
      // results first: a beat accepted on this edge cannot answer on the same edge
      if (out_valid_i && !out_stall_i) begin
        if (tag_results.size() == 0) begin
          $error("result beat with nothing expected: tag_word %h", tag_word_i);
          fails++;
        end else begin
          want = tag_results.pop_front();
          if (tag_word_i !== want.tag_word) begin
            $error("tag_word expected %h actual %h", want.tag_word, tag_word_i);
            fails++;
          end
          if (word_last_i !== want.word_last) begin
            $error("word_last expected %b actual %b", want.word_last, word_last_i);
            fails++;
          end
          if (is_verdict_i !== want.is_verdict) begin
            $error("is_verdict expected %b actual %b", want.is_verdict, is_verdict_i);
            fails++;
          end
          if (share_ok_i !== want.share_ok) begin
            $error("share_ok expected %b actual %b", want.share_ok, share_ok_i);
            fails++;
          end
          if (batch_ok_i !== want.batch_ok) begin
            $error("batch_ok expected %b actual %b", want.batch_ok, batch_ok_i);
            fails++;
          end
        end
      end
      if (cfg_we_i) key_q[cfg_idx_i] = cfg_data_i;
      if (in_valid_i && !in_stall_i)
        predict_beat(operation_i, share_x_i, share_len_i, verify_mode_i, data_byte_i);
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the share tagger: directed shares at the length,
// key and byte extremes, then random well-formed and broken share sequences
// under random idling on both channels, with key changes between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import shtag_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS     = 450;
  localparam int QUIET_AT  = 380;
  localparam int DRAIN_CYC = 800;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [63:0]  cfg_data_i = '0;
  logic         in_valid_i = 1'b0;
  logic         in_stall_o;
  logic [1:0]   operation_i = OP_BEGIN;
  logic [7:0]   share_x_i = '0;
  logic [7:0]   share_len_i = '0;
  logic         verify_mode_i = 1'b0;
  logic [7:0]   data_byte_i = '0;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  logic [63:0]  tag_word_o;
  logic         word_last_o;
  logic         is_verdict_o;
  logic         share_ok_o;
  logic         batch_ok_o;
  int           pending;
  int           mism;
  logic [255:0] digest;

  int beats_sent = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  always #5 clk_i = ~clk_i;

  share_hmac_sha256_tagger dut (.*);

  shtag_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .operation_i, .share_x_i, .share_len_i,
    .verify_mode_i, .data_byte_i, .out_valid_i(out_valid_o), .out_stall_i,
    .tag_word_i(tag_word_o), .word_last_i(word_last_o), .is_verdict_i(is_verdict_o),
    .share_ok_i(share_ok_o), .batch_ok_i(batch_ok_o),
    .pending_o(pending), .fail_o(mism), .digest_o(digest)
  );

  // receiver back-pressure in short bursts
  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send(input op_e op, input logic [7:0] x, input logic [7:0] len,
                      input logic vm, input logic [7:0] b);
    in_valid_i <= 1'b1;
    operation_i <= op;
    share_x_i <= x;
    share_len_i <= len;
    verify_mode_i <= vm;
    data_byte_i <= b;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    beats_sent++;
    if (beats_sent >= QUIET_AT) quiet = 1'b1;
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic write_key(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3);
    logic [63:0] ks [4];
    ks = '{k0, k1, k2, k3};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= i[1:0];
      cfg_data_i <= ks[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // drop whatever share is open, then let the block go quiet
  task automatic drain();
    send(OP_BEGIN, 8'h00, 8'h00, 1'b0, 8'h00);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  // one share; bad_pos >= 0 corrupts that expected byte
  task automatic run_share(input logic [7:0] x, input logic [7:0] len, input logic vm,
                           input int bad_pos, input int secret_cnt);
    logic [7:0] eb;
    send(OP_START, x, len, vm, 8'($urandom_range(255)));
    for (int i = 0; i < secret_cnt; i++)
      send(OP_SECRET, 8'($urandom_range(255)), 8'($urandom_range(255)),
           1'($urandom_range(1)),
           (len == 8'hff) ? ((i % 2) ? 8'hff : 8'h00) : 8'($urandom_range(255)));
    if (vm && secret_cnt == ((len > 64) ? 64 : len)) begin
      // idle the input so the predicted digest is settled before it is read
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      for (int i = 0; i < 32; i++) begin
        eb = digest[255 - 8*i -: 8];
        if (i == bad_pos) eb ^= 8'($urandom_range(1, 255));
        send(OP_EXPECT, 8'($urandom_range(255)), 8'($urandom_range(255)),
             1'($urandom_range(1)), eb);
      end
    end
  endtask

  task automatic random_phase(input int upto);
    int r, len, n;
    while (beats_sent < upto) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send(op_e'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)),
             1'($urandom_range(1)), 8'($urandom_range(255)));
      end else begin
        case ($urandom_range(9))
          0:       len = $urandom_range(0, 255);
          1, 2:    len = $urandom_range(9, 70);
          default: len = $urandom_range(0, 8);
        endcase
        n = (len > 64) ? 64 : len;
        // broken share: stops short and is dropped by the next start
        if (r < 14 && n > 0) n = $urandom_range(0, n - 1);
        run_share(8'($urandom_range(255)), 8'(len), 1'($urandom_range(1)),
                  ($urandom_range(9) < 3) ? $urandom_range(0, 31) : -1, n);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_key('1, '1, '1, '1);
    run_share(8'h00, 8'd0, 1'b0, -1, 0);          // zero length, tag
    run_share(8'hff, 8'd0, 1'b1, -1, 0);          // zero length, verify ok
    run_share(8'h00, 8'd255, 1'b0, -1, 64);       // clamped length, byte extremes
    run_share(8'h5a, 8'd1, 1'b1, 0, 1);           // verify fail drops batch
    run_share(8'h11, 8'd2, 1'b1, -1, 2);          // batch stays low
    send(OP_SECRET, 8'h00, 8'h00, 1'b0, 8'hff);   // stray secret byte
    send(OP_EXPECT, 8'h00, 8'h00, 1'b0, 8'hff);   // stray expected byte
    send(OP_BEGIN, 8'h00, 8'h00, 1'b0, 8'h00);
    run_share(8'h80, 8'd5, 1'b0, -1, 2);          // share left open, dropped by the next start
    run_share(8'h7f, 8'd64, 1'b1, 31, 64);
    drain();

    write_key({$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
    random_phase(200);
    drain();
    write_key('0, '0, '0, '0);
    random_phase(300);
    drain();
    write_key({$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
    random_phase(ITEMS);
    drain();

    if (mism == 0 && pending == 0) begin
      $display("PASS share_hmac_sha256_tagger");
    end else begin
      $display("FAIL share_hmac_sha256_tagger");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL share_hmac_sha256_tagger");
    $finish;
  end

endmodule
